### rtl/utf8_stream_transcoder_core_assert.svh
// ----------------------------------------------------------------------------
// utf8 transcoder assertion macros
// shared concurrent checks for the transcoder rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_TRANSCODER_CORE_ASSERT_SVH
`define UTF8_STREAM_TRANSCODER_CORE_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define U8ST_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("u8st assertion failed");

// next-cycle implication, ignored while reset is high
`define U8ST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("u8st assertion failed");

`endif

### rtl/utf8st_pkg.sv
// ----------------------------------------------------------------------------
// utf8st_pkg
// types and constants shared by the utf8 transcoder modules
// ----------------------------------------------------------------------------
`default_nettype none

package utf8st_pkg;

  localparam int unsigned ValueWidth = 21;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrWidth   = $clog2(FifoDepth);
  localparam int unsigned CountWidth = $clog2(FifoDepth + 1);

  localparam logic [7:0] LeadMin      = 8'hC2;
  localparam logic [7:0] LeadBadMin   = 8'hF8;
  localparam logic [7:0] Lead3Min     = 8'hE0;
  localparam logic [7:0] Lead4Min     = 8'hF0;
  localparam logic [ValueWidth-1:0] Utf16Max  = 21'h10FFFF;
  localparam logic [ValueWidth-1:0] SuppBase  = 21'h010000;
  localparam logic [ValueWidth-1:0] HighBase  = 21'h00D800;
  localparam logic [ValueWidth-1:0] LowBase   = 21'h00DC00;

  localparam logic [2:0] SeqLen2 = 3'd2;
  localparam logic [2:0] SeqLen3 = 3'd3;
  localparam logic [2:0] SeqLen4 = 3'd4;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_BAD_LEAD  = 3'd1,
    ERR_BAD_CONT  = 3'd2,
    ERR_OVERLONG  = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_RANGE     = 3'd5
  } err_code_t;

  typedef struct packed {
    logic                  string_done;
    logic                  last_of_run;
    err_code_t             error_code;
    logic [ValueWidth-1:0] unit_value;
  } result_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

### rtl/utf8st_decode.sv
// ----------------------------------------------------------------------------
// utf8st_decode
// sequence state and per-byte checking, decoding and utf-16 splitting
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_transcoder_core_assert.svh"

module utf8st_decode (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_string,
  input  wire logic              output_mode,
  output utf8st_pkg::push_t      push
);
  import utf8st_pkg::*;

  logic [2:0]            bytes_expected, bytes_expected_next;
  logic [2:0]            bytes_seen, bytes_seen_next;
  logic [ValueWidth-1:0] accumulator, accumulator_next;
  logic                  lead_low_bits_zero, lead_low_bits_zero_next;
  logic                  error_latched, error_latched_next;

  logic                  fail;
  err_code_t             fail_code;
  logic                  emit;
  logic [ValueWidth-1:0] emit_value;
  logic [ValueWidth-1:0] acc_cont;
  logic [2:0]            seen_inc;
  logic [ValueWidth-1:0] supp_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_expected     <= '0;
      bytes_seen         <= '0;
      accumulator        <= '0;
      lead_low_bits_zero <= 1'b0;
      error_latched      <= 1'b0;
    end else begin
      bytes_expected     <= bytes_expected_next;
      bytes_seen         <= bytes_seen_next;
      accumulator        <= accumulator_next;
      lead_low_bits_zero <= lead_low_bits_zero_next;
      error_latched      <= error_latched_next;
    end
  end

  assign acc_cont    = {accumulator[ValueWidth-7:0], data_byte[5:0]};
  assign seen_inc    = bytes_seen + 3'd1;
  assign supp_offset = emit_value - SuppBase;

  always_comb begin
    bytes_expected_next     = bytes_expected;
    bytes_seen_next         = bytes_seen;
    accumulator_next        = accumulator;
    lead_low_bits_zero_next = lead_low_bits_zero;
    error_latched_next      = error_latched;
    fail       = 1'b0;
    fail_code  = ERR_NONE;
    emit       = 1'b0;
    emit_value = '0;
    push       = '0;

    if (step) begin
      if (error_latched) begin
        // dropping until the end of the string
        if (end_of_string) begin
          error_latched_next = 1'b0;
        end
      end else if (bytes_expected == 3'd0) begin
        if (!data_byte[7]) begin
          emit       = 1'b1;
          emit_value = {{(ValueWidth-8){1'b0}}, data_byte};
        end else if (data_byte < LeadMin || data_byte >= LeadBadMin) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_LEAD;
        end else begin
          if (data_byte < Lead3Min) begin
            bytes_expected_next = SeqLen2;
            accumulator_next    = {{(ValueWidth-5){1'b0}}, data_byte[4:0]};
          end else if (data_byte < Lead4Min) begin
            bytes_expected_next = SeqLen3;
            accumulator_next    = {{(ValueWidth-4){1'b0}}, data_byte[3:0]};
          end else begin
            bytes_expected_next = SeqLen4;
            accumulator_next    = {{(ValueWidth-3){1'b0}}, data_byte[2:0]};
          end
          lead_low_bits_zero_next = (accumulator_next == '0);
          bytes_seen_next         = 3'd1;
          if (end_of_string) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end
        end
      end else begin
        if (data_byte[7:6] != 2'b10) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_CONT;
        end else if (bytes_seen == 3'd1 && lead_low_bits_zero &&
                     ((bytes_expected == SeqLen3 && !data_byte[5]) ||
                      (bytes_expected == SeqLen4 && data_byte[5:4] == 2'b00))) begin
          fail      = 1'b1;
          fail_code = ERR_OVERLONG;
        end else if (seen_inc >= bytes_expected) begin
          emit       = 1'b1;
          emit_value = acc_cont;
        end else if (end_of_string) begin
          fail      = 1'b1;
          fail_code = ERR_TRUNCATED;
        end else begin
          accumulator_next = acc_cont;
          bytes_seen_next  = seen_inc;
        end
      end

      if (emit) begin
        bytes_expected_next     = '0;
        bytes_seen_next         = '0;
        accumulator_next        = '0;
        lead_low_bits_zero_next = 1'b0;
        if (!output_mode || emit_value < SuppBase) begin
          push.count        = 2'd1;
          push.first        = '{end_of_string, 1'b1, ERR_NONE, emit_value};
        end else if (emit_value > Utf16Max) begin
          fail      = 1'b1;
          fail_code = ERR_RANGE;
        end else begin
          // surrogate pair from the 20-bit offset
          push.count  = 2'd2;
          push.first  = '{1'b0, 1'b0, ERR_NONE,
                          HighBase + {11'd0, supp_offset[19:10]}};
          push.second = '{end_of_string, 1'b1, ERR_NONE,
                          LowBase + {11'd0, supp_offset[9:0]}};
        end
      end

      if (fail) begin
        bytes_expected_next     = '0;
        bytes_seen_next         = '0;
        accumulator_next        = '0;
        lead_low_bits_zero_next = 1'b0;
        error_latched_next      = !end_of_string;
        push.count              = 2'd1;
        push.first              = '{end_of_string, 1'b1, fail_code, '0};
        push.second             = '0;
      end
    end
  end

  `U8ST_ASSERT_SAME(a_latched_no_seq, clk, rst, error_latched, bytes_expected == 3'd0)
  `U8ST_ASSERT_SAME(a_seen_below_len, clk, rst, bytes_expected != 3'd0,
                    bytes_seen != 3'd0 && bytes_seen < bytes_expected)
  `U8ST_ASSERT_SAME(a_latched_silent, clk, rst, error_latched, push.count == 2'd0)
  `U8ST_ASSERT_SAME(a_pair_utf16, clk, rst, push.count == 2'd2,
                    output_mode && !push.first.last_of_run)

endmodule

`default_nettype wire

### rtl/utf8st_out_fifo.sv
// ----------------------------------------------------------------------------
// utf8st_out_fifo
// small result queue taking up to two results a cycle, giving one while out_ready is high
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_stream_transcoder_core_assert.svh"

module utf8st_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire utf8st_pkg::push_t   push,
  output logic                     room_for_two,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output utf8st_pkg::result_t      out_result
);
  import utf8st_pkg::*;

  result_t               mem [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr, wr_ptr_next;
  logic [PtrWidth-1:0]   rd_ptr, rd_ptr_next;
  logic [CountWidth-1:0] count, count_next;
  logic                  pop;

  assign out_valid    = (count != '0);
  assign out_result   = mem[rd_ptr];
  assign pop          = out_valid && out_ready;
  assign room_for_two = (count <= CountWidth'(FifoDepth - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + PtrWidth'(push.count);
    rd_ptr_next = rd_ptr + PtrWidth'(pop);
    count_next  = count + CountWidth'(push.count) - CountWidth'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + PtrWidth'(1)] <= push.second;
    end
  end

  `U8ST_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CountWidth'(FifoDepth))
  `U8ST_ASSERT_SAME(a_push_has_room, clk, rst, push.count != 2'd0, room_for_two)
  `U8ST_ASSERT_NEXT(a_count_tracks, clk, rst, push.count == 2'd0 && pop,
                    count == $past(count) - CountWidth'(1))

endmodule

`default_nettype wire

### rtl/utf8_stream_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_transcoder_core
// utf-8 byte stream to utf-32 code points or utf-16 code units
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one utf-8 byte per beat, s_axis_tlast marks the last byte
//   of a string. m_axis carries one result per beat: a code point, a utf-16
//   unit or an error code; tlast marks the last result caused by one byte and
//   tuser marks the result that closes the string (none after an error mid-string).
//   cfg_data selects utf-32 (0) or utf-16 (1) output; write it only while the
//   block is idle. cfg_ready is always high.
//   a byte is registered on acceptance, decoded from the input register once
//   the queue has room for two results, and its results written to a
//   four-entry result queue.
//   one byte per cycle is accepted while the queue has room; a character from
//   0x10000 to 0x10FFFF in utf-16 mode gives two results. a byte waits in the
//   input register while the queue holds more than two results, and
//   s_axis_tready stays low while it waits.
//   when the receiver stalls, results wait in the queue and then s_axis_tready
//   drops; nothing is lost.
//   reset (synchronous, active high) empties the queue, clears the sequence
//   and error state, and selects utf-32 output.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_transcoder_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_axis_tdata: data_byte[7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tlast,
  // m_axis_tdata: unit_value[20:0], error_code[23:21]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,
  output logic             m_axis_tlast,
  // m_axis_tuser: string_done[0]
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  import utf8st_pkg::*;

  logic       in_valid, in_valid_next;
  logic [7:0] in_byte;
  logic       in_eos;
  logic       output_mode;
  logic       room_for_two;
  logic       step;
  logic       s_accept;
  push_t      push;
  result_t    out_result;

  assign cfg_ready     = 1'b1;
  assign step          = in_valid && room_for_two;
  assign s_axis_tready = !in_valid || step;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_next = in_valid;
    if (s_accept) begin
      in_valid_next = 1'b1;
    end else if (step) begin
      in_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid    <= 1'b0;
      output_mode <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
      if (cfg_valid && cfg_ready) begin
        output_mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_byte <= s_axis_tdata;
      in_eos  <= s_axis_tlast;
    end
  end

  utf8st_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .data_byte     (in_byte),
    .end_of_string (in_eos),
    .output_mode   (output_mode),
    .push          (push)
  );

  utf8st_out_fifo u_out_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room_for_two (room_for_two),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_result   (out_result)
  );

  assign m_axis_tdata = {out_result.error_code, out_result.unit_value};
  assign m_axis_tlast = out_result.last_of_run;
  assign m_axis_tuser = out_result.string_done;

endmodule

`default_nettype wire
